// ===== src/tlvd_pkg.sv =====
package tlvd_pkg;

    // Fixed framing of one chunk header: a 32-bit type and a 32-bit length.
    localparam int unsigned HDR_BYTES  = 8;
    localparam int unsigned WORD_BYTES = 4;

    // Width of the running file offset and of the file size register.
    localparam int unsigned OFFSET_W = 33;
    localparam int unsigned SIZE_W   = 32;

    // Kind of one result transfer.
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_STOP    = 2'd2
    } t_kind;

    // One result item.
    typedef struct packed {
        t_kind       kind;
        logic [31:0] chunk_type;
        logic [31:0] chunk_length;
        logic [7:0]  payload_byte;
        logic        last_of_chunk;
    } t_result;

endpackage

// ===== src/tlvd_parse.sv =====
module tlvd_parse (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [31:0]            i_cfg_wr_data,
    input  logic                   i_take,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_first_of_file,
    output logic                   o_res_valid,
    output tlvd_pkg::t_result      o_res
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_STOPPED = 2'd2
    } t_phase;

    logic [tlvd_pkg::SIZE_W-1:0]   r_file_size;
    logic [tlvd_pkg::OFFSET_W-1:0] r_offset, n_offset;
    t_phase                        r_phase, n_phase;
    logic [2:0]                    r_idx, n_idx;
    logic [31:0]                   r_type, n_type;
    logic [31:0]                   r_len, n_len;
    logic [31:0]                   r_rem, n_rem;

    // State as seen by this byte: a first-of-file byte restarts at offset zero.
    logic [tlvd_pkg::OFFSET_W-1:0] eff_offset;
    t_phase                        eff_phase;
    logic [2:0]                    eff_idx;
    logic [31:0]                   eff_type;
    logic [31:0]                   eff_len;
    logic [31:0]                   eff_rem;

    logic [tlvd_pkg::OFFSET_W-1:0] offset_inc;
    logic [31:0]                   type_acc;
    logic [31:0]                   len_acc;
    logic [31:0]                   rem_dec;
    logic [4:0]                    shift;
    logic                          short_rem;
    logic                          overrun;

    always_comb begin
        eff_offset = i_first_of_file ? '0 : r_offset;
        eff_phase  = i_first_of_file ? PH_HEADER : r_phase;
        eff_idx    = i_first_of_file ? 3'd0 : r_idx;
        eff_type   = i_first_of_file ? 32'd0 : r_type;
        eff_len    = i_first_of_file ? 32'd0 : r_len;
        eff_rem    = i_first_of_file ? 32'd0 : r_rem;
    end

    // Header byte assembly, little-endian, and the two bound checks.
    always_comb begin
        offset_inc = eff_offset + tlvd_pkg::OFFSET_W'(1);
        shift      = {eff_idx[1:0], 3'b000};
        type_acc   = eff_type;
        len_acc    = eff_len;
        if (eff_idx < 3'(tlvd_pkg::WORD_BYTES)) begin
            type_acc = eff_type | (32'(i_data_byte) << shift);
        end else begin
            len_acc = eff_len | (32'(i_data_byte) << shift);
        end
        short_rem = ({1'b0, eff_offset} + (tlvd_pkg::OFFSET_W + 1)'(tlvd_pkg::HDR_BYTES))
                    > (tlvd_pkg::OFFSET_W + 1)'(r_file_size);
        overrun   = ({1'b0, offset_inc} + (tlvd_pkg::OFFSET_W + 1)'(len_acc))
                    > (tlvd_pkg::OFFSET_W + 1)'(r_file_size);
        rem_dec   = (eff_rem != 32'd0) ? eff_rem - 32'd1 : 32'd0;
    end

    // Next state and the result of this byte.
    always_comb begin
        n_offset    = eff_offset;
        n_phase     = eff_phase;
        n_idx       = eff_idx;
        n_type      = eff_type;
        n_len       = eff_len;
        n_rem       = eff_rem;
        o_res_valid = 1'b0;
        o_res       = '0;
        case (eff_phase)
            PH_HEADER: begin
                if (eff_idx == 3'd0 && short_rem) begin
                    // Fewer than a header's worth of bytes left in the file.
                    n_phase     = PH_STOPPED;
                    o_res_valid = 1'b1;
                    o_res.kind  = tlvd_pkg::KIND_STOP;
                end else begin
                    n_offset = offset_inc;
                    n_idx    = eff_idx + 3'd1;
                    n_type   = type_acc;
                    n_len    = len_acc;
                    if (eff_idx == 3'd7) begin
                        o_res_valid        = 1'b1;
                        o_res.chunk_type   = type_acc;
                        o_res.chunk_length = len_acc;
                        if (overrun) begin
                            // The chunk would run past the end of the file.
                            n_phase    = PH_STOPPED;
                            n_type     = '0;
                            n_len      = '0;
                            o_res.kind = tlvd_pkg::KIND_STOP;
                        end else begin
                            n_rem      = len_acc;
                            o_res.kind = tlvd_pkg::KIND_HEADER;
                            if (len_acc == 32'd0) begin
                                o_res.last_of_chunk = 1'b1;
                                n_type              = '0;
                                n_len               = '0;
                            end else begin
                                n_phase = PH_PAYLOAD;
                            end
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                n_offset            = offset_inc;
                n_rem               = rem_dec;
                o_res_valid         = 1'b1;
                o_res.kind          = tlvd_pkg::KIND_PAYLOAD;
                o_res.chunk_type    = eff_type;
                o_res.chunk_length  = eff_len;
                o_res.payload_byte  = i_data_byte;
                o_res.last_of_chunk = (rem_dec == 32'd0);
                if (rem_dec == 32'd0) begin
                    n_phase = PH_HEADER;
                    n_idx   = 3'd0;
                    n_type  = '0;
                    n_len   = '0;
                end
            end
            default: begin
                // Stopped: bytes are dropped until the next file start.
            end
        endcase
    end

    // Parser state and the file size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_size <= '0;
            r_offset    <= '0;
            r_phase     <= PH_HEADER;
            r_idx       <= 3'd0;
            r_type      <= '0;
            r_len       <= '0;
            r_rem       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_file_size <= i_cfg_wr_data;
            end
            if (i_take) begin
                r_offset <= n_offset;
                r_phase  <= n_phase;
                r_idx    <= n_idx;
                r_type   <= n_type;
                r_len    <= n_len;
                r_rem    <= n_rem;
            end
        end
    end

endmodule

// ===== src/tlv_chunk_deframer_top.sv =====
// Type-length-value chunk deframer.
// Input channel: i_valid / o_stall carry one file byte per transfer in
// i_data_byte; i_first_of_file marks the first byte of a new file and
// restarts parsing at offset zero with that byte.
// Output channel: o_valid / i_stall carry one result per transfer: a chunk
// header (type and length, little-endian 32-bit words), a payload byte, or a
// stop result when a header or its chunk does not fit in the file size.
// i_cfg_wr_en / i_cfg_wr_data write the file size; it is sampled at each check.
// A result is registered in the output register, or in the skid register
// while that one waits. Throughput: one byte per cycle while o_stall is low;
// a header byte gives a result only if it is the eighth or if it stops parsing.
// A two-entry output stage (result register plus skid register) lets the
// block take a byte while a result waits; o_stall rises only when both
// entries are full, and results are held unchanged while i_stall is high.
// Reset (i_rst_n low, synchronous) empties the output stage, clears the file
// size to zero and returns the parser to the header phase at offset zero.
module tlv_chunk_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_of_file,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_result_kind,
    output logic [31:0] o_chunk_type,
    output logic [31:0] o_chunk_length,
    output logic [7:0]  o_payload_byte,
    output logic        o_last_of_chunk
);

    logic              take;
    logic              out_fire;
    logic              res_valid;
    tlvd_pkg::t_result res;
    logic              r_out_valid;
    tlvd_pkg::t_result r_out;
    logic              r_skid_valid;
    tlvd_pkg::t_result r_skid;

    assign take     = i_valid && !r_skid_valid;
    assign out_fire = r_out_valid && !i_stall;

    tlvd_parse u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_take          (take),
        .i_data_byte     (i_data_byte),
        .i_first_of_file (i_first_of_file),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    // Output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (take && res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload of the two entries.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (take && res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_stall         = r_skid_valid;
    assign o_valid         = r_out_valid;
    assign o_result_kind   = r_out.kind;
    assign o_chunk_type    = r_out.chunk_type;
    assign o_chunk_length  = r_out.chunk_length;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_last_of_chunk = r_out.last_of_chunk;

endmodule

// ===== src/tlvd_check.sv =====
module tlvd_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_result_kind,
    input logic [31:0] o_chunk_length,
    input logic [7:0]  o_payload_byte,
    input logic        o_last_of_chunk
);

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output stage not empty after reset");

    // A stalled result stays on the port unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_kind)
                               && $stable(o_chunk_length) && $stable(o_payload_byte))
        else $error("stalled result changed");

    // The input side stalls only after the output side held a result back.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stalled without output backpressure");

    // Only payload results carry a byte; stop results never mark a chunk end.
    a_payload_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind != tlvd_pkg::KIND_PAYLOAD
            |-> o_payload_byte == 8'd0
                && (o_result_kind != tlvd_pkg::KIND_STOP || !o_last_of_chunk))
        else $error("byte or chunk end on a non-payload result");

    // A header result ends the chunk exactly when its length is zero.
    a_empty_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == tlvd_pkg::KIND_HEADER
            |-> o_last_of_chunk == (o_chunk_length == 32'd0))
        else $error("header chunk end does not match its length");

endmodule

bind tlv_chunk_deframer_top tlvd_check u_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_result_kind   (o_result_kind),
    .o_chunk_length  (o_chunk_length),
    .o_payload_byte  (o_payload_byte),
    .o_last_of_chunk (o_last_of_chunk)
);

// ===== dv/tlvd_frame_checker.sv =====
`timescale 1ns / 1ps

module tlvd_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_of_file,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_result_kind,
    input  logic [31:0] i_chunk_type,
    input  logic [31:0] i_chunk_length,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_last_of_chunk,
    input  logic        i_end_check,
    output int          o_pending,
    output int          o_fail_count
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_STOPPED = 2'd2
    } t_phase;

    // Shadow copy of the parser state and the file size register.
    logic [31:0] size_reg;
    logic [32:0] offset;
    t_phase      phase;
    logic [2:0]  hdr_idx;
    logic [31:0] type_acc;
    logic [31:0] len_acc;
    logic [31:0] remaining;

    tlvd_pkg::t_result pending_results[$];
    int      n_errors = 0;
    bit      end_done = 1'b0;

    assign o_fail_count = n_errors;

    function automatic tlvd_pkg::t_result make_result(tlvd_pkg::t_kind kind,
                                                      logic [31:0] ctype,
                                                      logic [31:0] clen,
                                                      logic [7:0] data,
                                                      logic last);
        tlvd_pkg::t_result r;
        r.kind          = kind;
        r.chunk_type    = ctype;
        r.chunk_length  = clen;
        r.payload_byte  = data;
        r.last_of_chunk = last;
        return r;
    endfunction

    // Queues one expected result behind the ones already waiting.
    task automatic add_expected(input tlvd_pkg::t_result r);
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic restart_file();
        offset    = '0;
        phase     = PH_HEADER;
        hdr_idx   = '0;
        type_acc  = '0;
        len_acc   = '0;
        remaining = '0;
    endtask

    // Advances the parser by one accepted byte and queues the result it causes.
    task automatic parse_byte(input logic [7:0] data, input logic first);
        logic [33:0] reach;
        logic [31:0] ctype;
        logic [31:0] clen;
        logic        last;
        if (first) restart_file();
        if (phase == PH_HEADER) begin
            reach = {1'b0, offset} + 34'(tlvd_pkg::HDR_BYTES);
            if (hdr_idx == 3'd0 && reach > {2'b00, size_reg}) begin
                // Fewer than a full header left in the file.
                phase = PH_STOPPED;
                add_expected(make_result(tlvd_pkg::KIND_STOP, '0, '0, '0, 1'b0));
            end else begin
                if (hdr_idx < tlvd_pkg::WORD_BYTES)
                    type_acc = type_acc | (32'(data) << (8 * hdr_idx));
                else
                    len_acc = len_acc
                              | (32'(data) << (8 * (hdr_idx - tlvd_pkg::WORD_BYTES)));
                hdr_idx = hdr_idx + 3'd1;
                offset  = offset + 33'd1;
                if (hdr_idx == 3'd0) begin
                    ctype    = type_acc;
                    clen     = len_acc;
                    type_acc = '0;
                    len_acc  = '0;
                    reach    = {1'b0, offset} + {2'b00, clen};
                    if (reach > {2'b00, size_reg}) begin
                        // The chunk would run past the end of the file.
                        phase = PH_STOPPED;
                        add_expected(make_result(tlvd_pkg::KIND_STOP, ctype, clen,
                                                 '0, 1'b0));
                    end else begin
                        remaining = clen;
                        add_expected(make_result(tlvd_pkg::KIND_HEADER, ctype, clen,
                                                 '0, clen == '0));
                        if (clen != '0) begin
                            phase    = PH_PAYLOAD;
                            type_acc = ctype;
                            len_acc  = clen;
                        end
                    end
                end
            end
        end else if (phase == PH_PAYLOAD) begin
            offset = offset + 33'd1;
            if (remaining != '0) remaining = remaining - 32'd1;
            last = (remaining == '0);
            add_expected(make_result(tlvd_pkg::KIND_PAYLOAD, type_acc, len_acc,
                                     data, last));
            if (last) begin
                phase    = PH_HEADER;
                hdr_idx  = '0;
                type_acc = '0;
                len_acc  = '0;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            n_errors++;
        end
    endtask

    // Compare each result transfer first, then predict from the byte transfer of
    // the same edge, since a byte's result never leaves in its own cycle.
    always @(posedge i_clk) begin
        tlvd_pkg::t_result want;
        if (!i_rst_n) begin
            size_reg = '0;
            restart_file();
            pending_results.delete();
        end else begin
            if (i_cfg_wr_en) size_reg = i_cfg_wr_data;
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with nothing expected, kind %0d",
                           i_result_kind);
                    n_errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("result_kind", 32'(want.kind), 32'(i_result_kind));
                    check_field("chunk_type", want.chunk_type, i_chunk_type);
                    check_field("chunk_length", want.chunk_length, i_chunk_length);
                    check_field("payload_byte", 32'(want.payload_byte),
                                32'(i_payload_byte));
                    check_field("last_of_chunk", 32'(want.last_of_chunk),
                                32'(i_last_of_chunk));
                end
            end
            if (i_in_valid && !i_in_stall) parse_byte(i_data_byte, i_first_of_file);
            if (i_end_check && !end_done) begin
                end_done = 1'b1;
                if (pending_results.size() != 0) begin
                    $error("%0d expected results never arrived", pending_results.size());
                    n_errors++;
                end
            end
        end
        o_pending <= pending_results.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 80;
    localparam int RANDOM_BYTES = 1350;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic [7:0]  data_byte = '0;
    logic        first_of_file = 1'b0;
    logic        out_stall = 1'b0;
    logic        end_check = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic [1:0]  result_kind;
    logic [31:0] chunk_type;
    logic [31:0] chunk_length;
    logic [7:0]  payload_byte;
    logic        last_of_chunk;
    int          n_pending;
    int          fail_count;

    // Control shared by the stimulus and the receiver, and the watchdog count.
    bit idle_on = 1'b1;
    bit long_hold_req = 1'b0;
    int quiet_cycles = 0;

    // Bytes of the next stream; bit 8 carries the first-of-file flag.
    logic [8:0] stream_q[$];

    tlv_chunk_deframer_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_valid         (in_valid),
        .o_stall         (in_stall),
        .i_data_byte     (data_byte),
        .i_first_of_file (first_of_file),
        .o_valid         (out_valid),
        .i_stall         (out_stall),
        .o_result_kind   (result_kind),
        .o_chunk_type    (chunk_type),
        .o_chunk_length  (chunk_length),
        .o_payload_byte  (payload_byte),
        .o_last_of_chunk (last_of_chunk)
    );

    tlvd_frame_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_data_byte     (data_byte),
        .i_first_of_file (first_of_file),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_result_kind   (result_kind),
        .i_chunk_type    (chunk_type),
        .i_chunk_length  (chunk_length),
        .i_payload_byte  (payload_byte),
        .i_last_of_chunk (last_of_chunk),
        .i_end_check     (end_check),
        .o_pending       (n_pending),
        .o_fail_count    (fail_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 5);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Adds one entry at the end of the next stream.
    task automatic append_entry(input logic [8:0] entry);
        stream_q.insert(stream_q.size(), entry);
    endtask

    task automatic add_header(input logic [31:0] ctype, input logic [31:0] clen);
        for (int i = 0; i < 4; i++) append_entry({1'b0, ctype[8*i +: 8]});
        for (int i = 0; i < 4; i++) append_entry({1'b0, clen[8*i +: 8]});
    endtask

    task automatic add_payload(input int n);
        for (int i = 0; i < n; i++) append_entry({1'b0, 8'($urandom)});
    endtask

    // Waits until no result is outstanding and the parser has settled.
    task automatic wait_drained();
        do @(posedge i_clk); while (n_pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_file_size(input logic [31:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Offers one byte, with an optional idle burst first, until it transfers.
    task automatic send_byte(input logic [8:0] entry);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= entry[7:0];
        first_of_file <= entry[8];
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic send_stream();
        foreach (stream_q[i]) send_byte(stream_q[i]);
        in_valid <= 1'b0;
        stream_q.delete();
    endtask

    initial begin
        int          counted;
        int          mode;
        int          nchunks;
        int          total;
        int          tail;
        int          pay;
        int          cut;
        bit          hold_done;
        logic [31:0] clen;
        logic [31:0] fsize;

        counted   = 0;
        hold_done = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero file size stops at once, then a stopped byte is ignored.
        append_entry({1'b1, 8'h00});
        append_entry({1'b0, 8'hFF});
        send_stream();

        // Directed: full-size file with a one-byte chunk, a zero-length chunk and
        // a chunk whose length runs past the end of the file.
        set_file_size(32'hFFFF_FFFF);
        add_header(32'hFFFF_FFFF, 32'd1);
        append_entry({1'b0, 8'hFF});
        add_header(32'h0000_0000, 32'd0);
        add_header(32'h1234_5678, 32'hFFFF_FFF8);
        stream_q[0][8] = 1'b1;
        send_stream();

        // Random files, mostly well formed.
        while (counted < RANDOM_BYTES) begin
            if (counted > RANDOM_BYTES - 200) idle_on = 1'b0;
            mode = $urandom_range(0, 9);
            if (!hold_done && counted >= 400) begin
                // Long receiver hold-off while a long chunk keeps arriving.
                add_header($urandom, 32'd40);
                add_payload(40);
                stream_q[0][8] = 1'b1;
                set_file_size(32'd48);
                long_hold_req = 1'b1;
                hold_done = 1'b1;
                counted += 48;
                send_stream();
            end else if (mode <= 5) begin
                // Whole chunks, sometimes a short remainder and bytes past the end.
                nchunks = $urandom_range(1, 4);
                for (int c = 0; c < nchunks; c++) begin
                    clen = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom_range(1, 12));
                    add_header($urandom, clen);
                    add_payload(int'(clen));
                end
                total = stream_q.size();
                tail = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
                add_payload(tail + $urandom_range(0, 3));
                stream_q[0][8] = 1'b1;
                set_file_size(32'(total + tail));
                counted += total + ((tail != 0) ? 1 : 0);
                send_stream();
            end else if (mode == 6) begin
                // Last chunk overruns the file size.
                if ($urandom_range(0, 1) == 1) begin
                    clen = 32'($urandom_range(0, 6));
                    add_header($urandom, clen);
                    add_payload(int'(clen));
                end
                total = stream_q.size();
                clen = 32'($urandom_range(1, 12));
                add_header($urandom, clen);
                add_payload(int'(clen));
                stream_q[0][8] = 1'b1;
                set_file_size(32'(total + 8 + $urandom_range(0, int'(clen) - 1)));
                counted += total + 8;
                send_stream();
            end else if (mode == 7) begin
                // Wide sizes and lengths.
                clen = ($urandom_range(0, 1) == 1) ? 32'($urandom)
                                                   : 32'($urandom_range(0, 16));
                fsize = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'($urandom);
                pay = (clen > 32'd12) ? 12 : int'(clen);
                add_header($urandom, clen);
                add_payload(pay);
                stream_q[0][8] = 1'b1;
                set_file_size(fsize);
                counted += 8 + pay;
                send_stream();
            end else if (mode == 8) begin
                // Noise with scattered file starts; not counted.
                total = $urandom_range(10, 30);
                for (int i = 0; i < total; i++)
                    append_entry({($urandom_range(0, 5) == 0), 8'($urandom)});
                set_file_size(32'($urandom_range(0, 48)));
                send_stream();
            end else begin
                // Well-formed file, usually cut short; the next file restarts parsing.
                nchunks = $urandom_range(1, 3);
                for (int c = 0; c < nchunks; c++) begin
                    clen = 32'($urandom_range(0, 12));
                    add_header($urandom, clen);
                    add_payload(int'(clen));
                end
                total = stream_q.size();
                cut = $urandom_range(1, total);
                while (stream_q.size() > cut) void'(stream_q.pop_back());
                stream_q[0][8] = 1'b1;
                set_file_size(32'(total));
                counted += cut;
                send_stream();
            end
        end

        // Drain, let the block settle, then give the verdict.
        wait_drained();
        repeat (4) @(posedge i_clk);
        end_check <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
